// ----- rtl/core/irfir_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the impulse response FIR block.
// No dependencies; imported by every module of the block.
package irfir_pkg;

	// Default depth of the coefficient and history stores
	localparam int TAPS_DEF = 1024;

	// Field widths
	localparam int IDX_W  = 10;
	localparam int DATA_W = 24;
	localparam int TC_W   = 11;
	localparam int FRAC_W = 23;
	localparam int PROD_W = 2 * DATA_W;

	// Request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	// Configuration port
	localparam int   APB_AW            = 3;
	localparam int   APB_DW            = 32;
	localparam logic REG_IDX_TAP_COUNT = 1'b0;
	localparam logic [TC_W-1:0] TC_RESET = TC_W'(1);

	// Q1.23 limits
	localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified word handed from front to back
	typedef struct packed {
		logic                     is_coef;
		logic                     coef_ok;
		logic [IDX_W-1:0]         tap_index;
		logic signed [DATA_W-1:0] value;
	} irfir_item_t;

endpackage

// ----- rtl/core/irfir_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on irfir_pkg for default sizes.
module irfir_ram
	import irfir_pkg::*;
#(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/irfir_front.sv -----
`timescale 1ns / 1ps
// Input side: accepts words, classifies them and queues them for the back end.
// Depends on irfir_pkg.
module irfir_front
	import irfir_pkg::*;
#(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic [IDX_W-1:0]         tap_index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     clearing,
	output logic                     q_valid,
	output irfir_item_t              q_item,
	input  logic                     pop
);

	irfir_item_t       q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              accept;
	irfir_item_t       item_in;

	// Hold off input while the stores are being cleared or the queue is full
	assign in_stall = clearing || (cnt_q == QCNT_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;

	// Classify the incoming word
	always_comb begin
		item_in.is_coef   = (req_type == REQ_COEF);
		item_in.coef_ok   = (32'(tap_index) < 32'(TAPS));
		item_in.tap_index = tap_index;
		item_in.value     = value;
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_item  = q_mem_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("queue count did not advance on push");

endmodule

// ----- rtl/core/irfir_back.sv -----
`timescale 1ns / 1ps
// Execution side: clears the stores, writes taps, and runs the shared MAC
// over the history for each sample. Depends on irfir_pkg and irfir_ram.
module irfir_back
	import irfir_pkg::*;
#(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [TC_W-1:0]          tap_count,
	input  logic                     q_valid,
	input  irfir_item_t              q_item,
	output logic                     pop,
	output logic                     clearing,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] sample_out
);

	localparam int AW    = $clog2(TAPS);
	localparam int CNT_W = $clog2(TAPS + 1);
	localparam int ACC_W = PROD_W + 1 + $clog2(TAPS);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_ROUND = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             clr_addr_q;
	logic [AW-1:0]             wp_q;
	logic [AW-1:0]             pos_q;
	logic [CNT_W-1:0]          k_q;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          n_eff;
	logic                      rd_v_s1;
	logic                      mul_v_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic [DATA_W-1:0]         sample_q;
	logic                      out_free;
	logic                      in_range;

	logic                      coef_we;
	logic [AW-1:0]             coef_waddr;
	logic [DATA_W-1:0]         coef_wdata;
	logic [DATA_W-1:0]         coef_rd;
	logic                      hist_we;
	logic [AW-1:0]             hist_waddr;
	logic [DATA_W-1:0]         hist_wdata;
	logic [DATA_W-1:0]         hist_rd;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;

	// Clamp the tap count to one..TAPS
	always_comb begin
		if (tap_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(tap_count) > 32'(TAPS)) begin
			n_eff = CNT_W'(TAPS);
		end else begin
			n_eff = CNT_W'(tap_count);
		end
	end

	// Store write ports: zero during the clearing pass, else the popped word
	always_comb begin
		coef_we    = clearing || (pop && q_item.is_coef && q_item.coef_ok);
		coef_waddr = clearing ? clr_addr_q : AW'(q_item.tap_index);
		coef_wdata = clearing ? '0 : q_item.value;
		hist_we    = clearing || (pop && !q_item.is_coef);
		hist_waddr = clearing ? clr_addr_q : wp_q;
		hist_wdata = clearing ? '0 : q_item.value;
	end

	irfir_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (k_q[AW-1:0]),
		.rdata (coef_rd)
	);

	irfir_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TAPS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (pos_q),
		.rdata (hist_rd)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			wp_q       <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(TAPS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (pop && !q_item.is_coef) begin
						wp_q    <= (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + AW'(1);
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == n_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk taps forward and history backward
	always_ff @(posedge clk) begin
		if (pop && !q_item.is_coef) begin
			k_q   <= '0;
			pos_q <= wp_q;
			n_q   <= n_eff;
		end else if (state_q == ST_MAC) begin
			k_q   <= k_q + CNT_W'(1);
			pos_q <= (pos_q == '0) ? AW'(TAPS - 1) : pos_q - AW'(1);
		end
	end

	// MAC pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == ST_MAC);
			mul_v_s2 <= rd_v_s1;
		end
	end

	// Multiply, then accumulate; add the rounding half before the final shift
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(coef_rd) * $signed(hist_rd);
		if (pop && !q_item.is_coef) begin
			acc_q <= '0;
		end else if (mul_v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end else if (state_q == ST_DRAIN && !rd_v_s1) begin
			acc_q <= acc_q + (ACC_W'(1) << (FRAC_W - 1));
		end
	end

	// Saturate to Q1.23: in range when all bits above the result match its sign
	assign in_range = (&acc_q[ACC_W-1:FRAC_W+DATA_W-1]) || !(|acc_q[ACC_W-1:FRAC_W+DATA_W-1]);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_ROUND && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND && out_free) begin
			if (in_range) begin
				sample_q <= acc_q[FRAC_W+DATA_W-1:FRAC_W];
			end else begin
				sample_q <= acc_q[ACC_W-1] ? Q_MIN : Q_MAX;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = $signed(sample_q);

	a_round_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> !rd_v_s1 && !mul_v_s2)
		else $error("rounding with products still in flight");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> k_q < n_q)
		else $error("tap counter past tap count");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !out_valid_q && !rd_v_s1)
		else $error("activity during clearing pass");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < 32'(TAPS))
		else $error("write pointer out of range");

endmodule

// ----- rtl/core/impulse_response_fir_top.sv -----
`timescale 1ns / 1ps
// Top level of the impulse response FIR: configuration register, front end
// and back end. Depends on irfir_pkg, irfir_front, irfir_back.

// Direct-form FIR with TAPS stored Q1.23 coefficients and a circular history.
// A coefficient word is written to its store when popped; a sample word runs
// n taps, n being tap_count clamped to 1..TAPS, through the single shared
// multiply-accumulate that reads one tap and one history entry per cycle.
// After reset the block runs a clearing pass over every entry of both stores
// and holds in_stall high meanwhile. Write tap_count only while no word is in
// flight, since a queued sample uses the tap count in force when it starts.
// A two-word queue sits between input and execution, and a result register
// lets the next word enter while a result waits on out_stall.
module impulse_response_fir_top
	import irfir_pkg::*;
#(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_AW-1:0]        paddr,
	input  logic [APB_DW-1:0]        pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic [IDX_W-1:0]         tap_index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] sample_out
);

	logic [TC_W-1:0] tap_count_q;
	logic            clearing;
	logic            q_valid;
	irfir_item_t     q_item;
	logic            pop;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TC_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_IDX_TAP_COUNT) begin
			tap_count_q <= pwdata[TC_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_IDX_TAP_COUNT) ? APB_DW'(tap_count_q) : '0;

	irfir_front #(
		.TAPS (TAPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.tap_index (tap_index),
		.value     (value),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	irfir_back #(
		.TAPS (TAPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tap_count  (tap_count_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

endmodule

// ----- test/tb_impulse_response_fir_top.sv -----
`timescale 1ns / 1ps
// Testbench for impulse_response_fir_top: directed and random sample and tap words,
// tap_count changes over APB, each output checked against a convolution model kept here.
// Depends on irfir_pkg and the RTL of the block.

module tb_impulse_response_fir_top;
	import irfir_pkg::*;

	localparam int     TAPS          = TAPS_DEF;
	localparam int     REG_IDX_SPARE = 1;
	localparam int     CYCLE_LIMIT   = 900_000;
	localparam int     DRAIN_CYCLES  = 32;
	localparam int     MAX_IDLE      = 16;
	localparam longint SAT_HI        = 64'sd8388607;
	localparam longint SAT_LO        = -64'sd8388608;

	// Convolution model: tap and history stores, write pointer, tap_count,
	// and the outputs still owed by the block.
	class fir_tap_sum;
		logic signed [DATA_W-1:0] coef_mem [TAPS];
		logic signed [DATA_W-1:0] hist_mem [TAPS];
		int unsigned              wr_ptr;
		logic [TC_W-1:0]          tap_count;
		logic signed [DATA_W-1:0] pending_out [$];
		int                       sample_count;
		int                       coef_count;
		int                       checked;
		int                       fail_count;

		function new();
			foreach (coef_mem[i]) begin
				coef_mem[i] = '0;
				hist_mem[i] = '0;
			end
			wr_ptr       = 0;
			tap_count    = TC_RESET;
			sample_count = 0;
			coef_count   = 0;
			checked      = 0;
			fail_count   = 0;
		endfunction

		// Zero counts as one tap, anything past the store depth as the full depth
		function int eff_taps();
			if (tap_count == 0)
				return 1;
			if (tap_count > TAPS)
				return TAPS;
			return tap_count;
		endfunction

		function void report(string what);
			fail_count++;
			$display("MISMATCH @%0t: %s", $realtime, what);
		endfunction

		// Note one accepted word; a sample word owes one output
		function void take_word(logic req, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] val);
			int unsigned pos;
			int          n;
			longint      acc;
			longint      y;
			if (req == REQ_COEF) begin
				if (idx < TAPS)
					coef_mem[idx] = val;
				coef_count++;
				return;
			end
			sample_count++;
			hist_mem[wr_ptr] = val;
			n   = eff_taps();
			acc = 0;
			pos = wr_ptr;
			for (int k = 0; k < n; k++) begin
				acc += longint'(coef_mem[k]) * longint'(hist_mem[pos]);
				pos = (pos == 0) ? TAPS - 1 : pos - 1;
			end
			// round half up, then clip to Q1.23
			y = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			if (y > SAT_HI)
				y = SAT_HI;
			if (y < SAT_LO)
				y = SAT_LO;
			pending_out.push_back(y[DATA_W-1:0]);
			wr_ptr = (wr_ptr + 1) % TAPS;
		endfunction

		function void check_output(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (pending_out.size() == 0) begin
				report($sformatf("sample_out %0d with no output owed", got));
				return;
			end
			want = pending_out.pop_front();
			checked++;
			if (got !== want)
				report($sformatf("sample_out %0d, expected %0d", got, want));
		endfunction

		function int pending();
			return pending_out.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_AW-1:0]        paddr;
	logic [APB_DW-1:0]        pwdata;
	logic [APB_DW-1:0]        prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_stall;
	logic                     req_type;
	logic [IDX_W-1:0]         tap_index;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] sample_out;

	fir_tap_sum sb = new();
	logic       tx_idle_on = 1'b1;
	logic       rx_idle_on = 1'b1;
	int         settings_seen = 0;
	int         cycles = 0;

	impulse_response_fir_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs still owed", cycles, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check every accepted output word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(sample_out);
	end

	// Output side: hold stall for a random count per word, then take the word
	initial begin
		int unsigned hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// All driving tasks start and end right after a falling edge
	task automatic send_word(logic req, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] val);
		int unsigned gap;
		logic        taken;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		req_type  = req;
		tap_index = idx;
		value     = val;
		do begin
			@(posedge clk);
			taken = !in_stall;
			if (taken)
				sb.take_word(req, idx, val);
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic cfg_write(int idx, logic [APB_DW-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = APB_AW'(idx * 4);
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_IDX_TAP_COUNT) begin
			sb.tap_count = data[TC_W-1:0];
			settings_seen++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Read tap_count back and compare with the model's copy
	task automatic cfg_check();
		logic [APB_DW-1:0] got;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = APB_AW'(REG_IDX_TAP_COUNT * 4);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got !== APB_DW'(sb.tap_count))
			sb.report($sformatf("tap_count reads %0d, expected %0d", got, sb.tap_count));
	endtask

	// Drop valid, wait for owed outputs, then let queued tap words drain
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_q(int shift);
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = Q_MAX;
			1: v = Q_MIN;
			2: v = '0;
			3: begin
				v = DATA_W'($urandom_range(0, 255));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				v = DATA_W'($urandom);
				v = v >>> shift;
			end
		endcase
		return v;
	endfunction

	initial begin
		logic [TC_W-1:0] plan [14];
		int              eff;
		int              n_items;
		int              shift;
		logic [APB_DW-1:0] wdata;

		plan = '{11'd2047, 11'd7, 11'd1, 11'd40, 11'd1024, 11'd3, 11'd100,
			11'd16, 11'd1023, 11'd2, 11'd64, 11'd11, 11'd5, 11'd30};
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		req_type  = REQ_SAMPLE;
		tap_index = '0;
		value     = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Reset value of tap_count, then single-tap cases
		cfg_check();
		send_word(REQ_SAMPLE, 10'h3FF, Q_MAX);
		send_word(REQ_COEF, 10'h000, Q_MIN);
		send_word(REQ_COEF, 10'h3FF, Q_MAX);
		send_word(REQ_COEF, 10'h155, 24'sh2AAAAA);
		send_word(REQ_COEF, 10'h2AA, 24'sh555555);
		send_word(REQ_SAMPLE, 10'h000, Q_MIN);
		send_word(REQ_SAMPLE, 10'h2AA, Q_MAX);
		// rounding ties with a one-LSB tap
		send_word(REQ_COEF, 10'h000, 24'sh000001);
		send_word(REQ_SAMPLE, 10'h155, 24'sh400000);
		send_word(REQ_SAMPLE, 10'h000, 24'shC00000);
		send_word(REQ_SAMPLE, 10'h000, 24'sh000000);
		send_word(REQ_SAMPLE, 10'h3FF, 24'shFFFFFF);
		send_word(REQ_COEF, 10'h000, Q_MIN);

		// Zero taps acts as one
		settle();
		cfg_write(REG_IDX_TAP_COUNT, '0);
		cfg_check();
		repeat (3) send_word(REQ_SAMPLE, IDX_W'($urandom), pick_q(0));

		// Two full-scale taps drive the sum below the floor
		settle();
		cfg_write(REG_IDX_TAP_COUNT, 32'd2);
		cfg_check();
		send_word(REQ_COEF, 10'h001, Q_MIN);
		send_word(REQ_SAMPLE, 10'h000, Q_MAX);
		send_word(REQ_SAMPLE, 10'h000, Q_MAX);

		// Random phases over a spread of tap counts
		foreach (plan[p]) begin
			settle();
			if (p == 4) begin
				cfg_write(REG_IDX_SPARE, 32'h0000_0005);
				cfg_check();
			end
			wdata = APB_DW'(plan[p]);
			if (p == 1)
				wdata = {21'h1FFFFF, plan[p]};
			cfg_write(REG_IDX_TAP_COUNT, wdata);
			cfg_check();
			tx_idle_on = (p % 3 != 2);
			rx_idle_on = (p % 4 != 1);
			eff     = sb.eff_taps();
			n_items = (eff > 128) ? 12 : 48;
			shift   = $clog2(eff);
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 9) < 3) begin
					if ($urandom_range(0, 9) < 7)
						send_word(REQ_COEF, IDX_W'($urandom_range(0, eff - 1)),
							pick_q(shift));
					else
						send_word(REQ_COEF, IDX_W'($urandom), pick_q(shift));
				end else begin
					send_word(REQ_SAMPLE, IDX_W'($urandom), pick_q(0));
				end
			end
		end

		// Full depth again over the whole history
		settle();
		cfg_write(REG_IDX_TAP_COUNT, 32'(TAPS));
		cfg_check();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int i = 0; i < 10; i++) begin
			if (i % 3 == 0)
				send_word(REQ_COEF, IDX_W'($urandom), pick_q(10));
			else
				send_word(REQ_SAMPLE, IDX_W'($urandom), pick_q(0));
		end

		settle();
		$display("covered %0d sample words and %0d tap writes over %0d tap_count settings",
			sb.sample_count, sb.coef_count, settings_seen);
		$display("%0d outputs compared, %0d mismatches, %0d cycles",
			sb.checked, sb.fail_count, cycles);
		if (sb.fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
